[rtl/core/ptip_pkg.sv]
// Shared types, register codes and character constants for the text-to-integer parser.
package ptip_pkg;

	// Count limit of the consumed field; it saturates at the smaller of this and 255.
	localparam int unsigned MAX_COUNT = 255;
	localparam logic [7:0] CountLimit = (MAX_COUNT < 255) ? 8'(MAX_COUNT) : 8'd255;

	// Configuration register indexes.
	localparam int unsigned CfgIndexWidth = 3;
	localparam logic [CfgIndexWidth-1:0] RegRadix      = 3'd0;
	localparam logic [CfgIndexWidth-1:0] RegFillChar   = 3'd1;
	localparam logic [CfgIndexWidth-1:0] RegFillMode   = 3'd2;
	localparam logic [CfgIndexWidth-1:0] RegMinusChar  = 3'd3;
	localparam logic [CfgIndexWidth-1:0] RegPlusChar   = 3'd4;
	localparam logic [CfgIndexWidth-1:0] RegLetterCase = 3'd5;

	// Fill mode codes.
	localparam logic [1:0] FillLead  = 2'd0;
	localparam logic [1:0] FillTrail = 2'd1;
	localparam logic [1:0] FillInner = 2'd2;

	// Letter case codes.
	localparam logic [1:0] CaseEither = 2'd0;
	localparam logic [1:0] CaseUpper  = 2'd1;
	localparam logic [1:0] CaseLower  = 2'd2;

	// Character constants.
	localparam logic [7:0] ChDigit0   = 8'd48;
	localparam logic [7:0] ChDigit9   = 8'd57;
	localparam logic [7:0] ChUpperA   = 8'd65;
	localparam logic [7:0] ChUpperZ   = 8'd90;
	localparam logic [7:0] ChLowerA   = 8'd97;
	localparam logic [7:0] ChLowerZ   = 8'd122;
	localparam logic [7:0] UpperShift = 8'd55;
	localparam logic [7:0] LowerShift = 8'd87;
	localparam logic [5:0] MaxRadix   = 6'd36;

	// Reset values of the registers.
	localparam logic [5:0] RadixReset = 6'd10;
	localparam logic [7:0] MinusReset = 8'd45;
	localparam logic [7:0] PlusReset  = 8'd43;

	typedef enum logic [2:0] {
		PH_LEAD   = 3'd0,
		PH_SIGN   = 3'd1,
		PH_INNER  = 3'd2,
		PH_DIGITS = 3'd3,
		PH_DONE   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [63:0] value;
		logic [7:0]  consumed;
	} out_item_t;

	typedef struct packed {
		logic [5:0] radix;
		logic [7:0] fill_char;
		logic [1:0] pad_mode;
		logic [7:0] minus_char;
		logic [7:0] plus_char;
		logic [1:0] letter_case;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic        negative;
		logic [63:0] acc;
		logic [7:0]  count;
	} parse_state_t;

endpackage

[rtl/core/ptip_cfg.sv]
// Configuration register file of the text-to-integer parser.
module ptip_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [ptip_pkg::CfgIndexWidth-1:0]   cfg_index,
	input  logic [7:0]                           cfg_data,
	output ptip_pkg::cfg_t                       cfg
);
	import ptip_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix       <= RadixReset;
			cfg_q.fill_char   <= 8'd0;
			cfg_q.pad_mode    <= FillLead;
			cfg_q.minus_char  <= MinusReset;
			cfg_q.plus_char   <= PlusReset;
			cfg_q.letter_case <= CaseEither;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegRadix:      cfg_q.radix       <= cfg_data[5:0];
				RegFillChar:   cfg_q.fill_char   <= cfg_data;
				RegFillMode:   cfg_q.pad_mode    <= cfg_data[1:0];
				RegMinusChar:  cfg_q.minus_char  <= cfg_data;
				RegPlusChar:   cfg_q.plus_char   <= cfg_data;
				RegLetterCase: cfg_q.letter_case <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

endmodule

[rtl/core/ptip_step.sv]
// Combinational parse step: one character against the current parse state.
module ptip_step (
	input  ptip_pkg::parse_state_t cur,
	input  ptip_pkg::in_item_t     item,
	input  ptip_pkg::cfg_t         cfg,
	output ptip_pkg::parse_state_t nxt,
	output logic                   emit,
	output ptip_pkg::out_item_t    result
);
	import ptip_pkg::*;

	parse_state_t st;
	logic [7:0]   c;
	logic [5:0]   base;
	logic         lead_skip;
	logic         inner_skip;
	logic         upper_ok;
	logic         lower_ok;
	logic         is_digit;
	logic [7:0]   dval;
	logic         digit_ok;
	logic [7:0]   cnt_inc;
	logic [63:0]  product;
	logic         at_sign;
	logic         at_inner;

	always_comb begin
		// A first character restarts the parse before it is looked at.
		if (item.first) begin
			st.phase    = PH_LEAD;
			st.negative = 1'b0;
			st.acc      = 64'd0;
			st.count    = 8'd0;
		end else begin
			st = cur;
		end
	end

	assign c          = item.ch;
	assign base       = (cfg.radix > MaxRadix) ? MaxRadix : cfg.radix;
	assign lead_skip  = (cfg.fill_char != 8'd0) && (cfg.pad_mode == FillLead);
	assign inner_skip = (cfg.fill_char != 8'd0) && (cfg.pad_mode == FillInner);
	assign upper_ok   = (cfg.letter_case != CaseLower);
	assign lower_ok   = (cfg.letter_case != CaseUpper);

	always_comb begin
		is_digit = 1'b1;
		dval     = 8'd0;
		if (c >= ChDigit0 && c <= ChDigit9) begin
			dval = c - ChDigit0;
		end else if (upper_ok && c >= ChUpperA && c <= ChUpperZ) begin
			dval = c - UpperShift;
		end else if (lower_ok && c >= ChLowerA && c <= ChLowerZ) begin
			dval = c - LowerShift;
		end else begin
			is_digit = 1'b0;
		end
	end

	assign digit_ok = is_digit && (dval < {2'b00, base});
	assign cnt_inc  = (st.count < CountLimit) ? st.count + 8'd1 : st.count;
	assign product  = st.acc * {58'd0, base};
	assign at_sign  = (st.phase == PH_LEAD) || (st.phase == PH_SIGN);
	assign at_inner = at_sign || (st.phase == PH_INNER);

	always_comb begin
		nxt  = st;
		emit = 1'b0;
		if (st.phase == PH_LEAD && lead_skip && c == cfg.fill_char) begin
			nxt.count = cnt_inc;
		end else if (at_sign && cfg.minus_char != 8'd0 && c == cfg.minus_char) begin
			nxt.phase    = PH_INNER;
			nxt.negative = 1'b1;
			nxt.count    = cnt_inc;
		end else if (at_sign && cfg.plus_char != 8'd0 && c == cfg.plus_char) begin
			nxt.phase = PH_INNER;
			nxt.count = cnt_inc;
		end else if (at_inner && inner_skip && c == cfg.fill_char) begin
			nxt.phase = PH_INNER;
			nxt.count = cnt_inc;
		end else if (at_inner || st.phase == PH_DIGITS) begin
			if (digit_ok) begin
				nxt.phase = PH_DIGITS;
				nxt.acc   = product + {56'd0, dval};
				nxt.count = cnt_inc;
			end else begin
				nxt.phase = PH_DONE;
				emit      = 1'b1;
			end
		end
	end

	assign result.value    = st.negative ? (64'd0 - st.acc) : st.acc;
	assign result.consumed = st.count;

endmodule

[rtl/core/padded_text_to_integer_parser.sv]
// Top level of the streaming padded text-to-integer parser.
//
// Characters arrive one per beat on the input channel (in_valid, in_stall, in_data).
// A beat with first set starts a new string; an unfinished parse is dropped without
// a result. Optional fill, a sign, more fill and then digits in the configured radix
// are consumed; the first character that fits none of these ends the string and
// produces one result beat (value, consumed) on the output channel (out_valid,
// out_stall, out_data). Characters after that are ignored until the next first.
//
// A character taken into the input register is parsed from there; a terminating one
// loads the result register, which drives out_valid. Throughput is one character per
// cycle while in_stall is low; the multiply-by-radix and add into the 64-bit
// accumulator is combinational, between the input register and the result register.
//
// When the receiver stalls, the result register holds its beat. Characters that
// produce no result still flow through; only a terminating character waits in the
// input register, and in_stall is raised while it does.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are taken every
// cycle and belong between strings. Reset restores the register defaults (radix 10,
// no fill, '-' and '+' signs, either letter case) and empties both stages.
module padded_text_to_integer_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  ptip_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output ptip_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ptip_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [7:0]                         cfg_data
);
	import ptip_pkg::*;

	cfg_t         cfg;
	logic         valid_s1;
	in_item_t     item_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         emit;
	out_item_t    result;
	logic         out_valid_q;
	out_item_t    out_item_q;
	logic         go;
	logic         accept;

	ptip_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ptip_step u_step (
		.cur    (state_q),
		.item   (item_s1),
		.cfg    (cfg),
		.nxt    (state_nxt),
		.emit   (emit),
		.result (result)
	);

	// The held character is parsed unless it would produce a result while the
	// result register still holds a beat that the receiver has not taken.
	assign go       = valid_s1 && (!emit || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	// Parse state advances once per parsed character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase    <= PH_LEAD;
			state_q.negative <= 1'b0;
			state_q.acc      <= 64'd0;
			state_q.count    <= 8'd0;
		end else if (go) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_item_q;

endmodule

[rtl/core/ptip_chk.sv]
// Port-level checker for the text-to-integer parser, bound to the top level.
module ptip_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input ptip_pkg::out_item_t out_data
);
	import ptip_pkg::*;

	// A held result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// The input side only stalls behind a result the receiver is holding off.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// A new result appears only behind a taken character: the character first loads the
	// input register, and its parse then loads the result register.
	a_rise_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a preceding character");

	// The consumed count never passes its saturation limit.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.consumed <= CountLimit)
		else $error("consumed count above limit");

endmodule

bind padded_text_to_integer_parser ptip_chk u_ptip_chk (.*);

[tb/sv/padded_text_to_integer_parser_checker.sv]
// Checker that predicts each parse result and compares it with the result channel.
module padded_text_to_integer_parser_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  ptip_pkg::in_item_t                 in_data,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  ptip_pkg::out_item_t                out_data,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [ptip_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [7:0]                         cfg_data,
	output int                                 fail_count,
	output int                                 results_pending
);
	import ptip_pkg::*;

	localparam logic [7:0] NoDigit = 8'hFF;

	cfg_t         regs;
	parse_state_t parse;
	out_item_t    expected_results[$];
	int           errors;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("mismatch: %s: got %0h, expected %0h", what, got, want);
	endtask

	function automatic logic [7:0] digit_value(input logic [7:0] c, input logic [1:0] lc);
		if (c >= ChDigit0 && c <= ChDigit9) return c - ChDigit0;
		if (lc != CaseLower && c >= ChUpperA && c <= ChUpperZ) return c - UpperShift;
		if (lc != CaseUpper && c >= ChLowerA && c <= ChLowerZ) return c - LowerShift;
		return NoDigit;
	endfunction

	task automatic take_char();
		if (parse.count < CountLimit) parse.count++;
	endtask

	// Advances the parse by one character and queues a result on the stopping character.
	task automatic parse_char(input logic [7:0] c, input logic restart);
		logic [5:0] base;
		logic       lead_skip;
		logic       inner_skip;
		logic [7:0] d;
		out_item_t  res;
		base = (regs.radix > MaxRadix) ? MaxRadix : regs.radix;
		lead_skip = (regs.fill_char != 8'd0) && (regs.pad_mode == FillLead);
		inner_skip = (regs.fill_char != 8'd0) && (regs.pad_mode == FillInner);
		if (restart) parse = '{phase: PH_LEAD, negative: 1'b0, acc: '0, count: '0};
		if (parse.phase == PH_DONE) return;
		if (parse.phase == PH_LEAD) begin
			if (lead_skip && c == regs.fill_char) begin
				take_char();
				return;
			end
			parse.phase = PH_SIGN;
		end
		if (parse.phase == PH_SIGN) begin
			parse.phase = PH_INNER;
			if (regs.minus_char != 8'd0 && c == regs.minus_char) begin
				parse.negative = 1'b1;
				take_char();
				return;
			end
			if (regs.plus_char != 8'd0 && c == regs.plus_char) begin
				take_char();
				return;
			end
		end
		if (parse.phase == PH_INNER) begin
			if (inner_skip && c == regs.fill_char) begin
				take_char();
				return;
			end
			parse.phase = PH_DIGITS;
		end
		d = digit_value(c, regs.letter_case);
		if (d < {2'b00, base}) begin
			parse.acc = parse.acc * 64'(base) + 64'(d);
			take_char();
			return;
		end
		res.value = parse.negative ? 64'd0 - parse.acc : parse.acc;
		res.consumed = parse.count;
		parse.phase = PH_DONE;
		expected_results.push_back(res);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			regs = '{radix: RadixReset, fill_char: 8'd0, pad_mode: FillLead,
				minus_char: MinusReset, plus_char: PlusReset, letter_case: CaseEither};
			parse = '{phase: PH_LEAD, negative: 1'b0, acc: '0, count: '0};
			expected_results.delete();
			errors = 0;
			fail_count <= 0;
			results_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					RegRadix:      regs.radix = cfg_data[5:0];
					RegFillChar:   regs.fill_char = cfg_data;
					RegFillMode:   regs.pad_mode = cfg_data[1:0];
					RegMinusChar:  regs.minus_char = cfg_data;
					RegPlusChar:   regs.plus_char = cfg_data;
					RegLetterCase: regs.letter_case = cfg_data[1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result beat with nothing expected", out_data.value, '0);
				end else begin
					want = expected_results.pop_front();
					if (out_data.value !== want.value)
						report_mismatch("value", out_data.value, want.value);
					if (out_data.consumed !== want.consumed)
						report_mismatch("consumed", 64'(out_data.consumed), 64'(want.consumed));
				end
			end
			if (in_valid && !in_stall) parse_char(in_data.ch, in_data.first);
			fail_count <= errors;
			results_pending <= expected_results.size();
		end
	end

endmodule

[tb/sv/padded_text_to_integer_parser_tb.sv]
// Testbench top: drives characters and register writes into the parser and gives the verdict.
module padded_text_to_integer_parser_tb;
	import ptip_pkg::*;

	// Codes outside the named fill and case modes; the block treats them as trail and either.
	localparam logic [1:0] FillModeSpare = 2'd3;
	localparam logic [1:0] CaseModeSpare = 2'd3;

	localparam int NumPhases    = 11;
	localparam int RandomItems  = 1850;
	localparam int HoldPhase    = 2;
	localparam int HoldCycles   = 300;
	localparam int SettleCycles = 6;
	localparam int CycleLimit   = 400000;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_stall;
	out_item_t                out_data;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [7:0]               cfg_data;
	int                       fail_count;
	int                       results_pending;

	// The stimulus keeps its own view of the registers so it can build strings that parse.
	logic [7:0] cfg_words [8];
	logic [5:0] radix_now;
	logic [7:0] fill_now;
	logic [7:0] minus_now;
	logic [7:0] plus_now;
	logic [1:0] case_now;

	int chars_sent = 0;
	int phase_no = -1;
	int idle_odds = 10;
	int cycle_count = 0;

	padded_text_to_integer_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	padded_text_to_integer_parser_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.results_pending (results_pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// A hung handshake or a lost result ends the run here.
	initial begin
		wait (cycle_count >= CycleLimit);
		$display("padded_text_to_integer_parser test failed");
		$finish;
	end

	// Result side. It stalls in random bursts whose odds follow the current phase, and
	// once, in its own count of cycles, it holds off long enough that a terminating
	// character gets stuck in the input register and the block stalls its input.
	initial begin
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (!held && phase_no == HoldPhase) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Offers one character and waits for the beat to be taken. Valid is dropped only
	// when an idle burst comes first, so it never falls and rises in one step.
	task automatic send_char(input logic [7:0] c, input logic restart);
		if (idle_odds > 0 && $urandom_range(0, 99) < idle_odds) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_data <= '{ch: c, first: restart};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		chars_sent++;
	endtask

	// Waits until every expected result has come out, then lets a character that
	// produces no result finish its parse before anything changes.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	// Writes all eight register indexes back to back; the two spare indexes have no
	// register behind them and must change nothing.
	task automatic write_config();
		for (int i = 0; i < 8; i++) begin
			cfg_index <= CfgIndexWidth'(i);
			cfg_data <= cfg_words[i];
			cfg_valid <= 1'b1;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		radix_now = cfg_words[RegRadix][5:0];
		fill_now = cfg_words[RegFillChar];
		minus_now = cfg_words[RegMinusChar];
		plus_now = cfg_words[RegPlusChar];
		case_now = cfg_words[RegLetterCase][1:0];
	endtask

	// Unused upper bits of the narrow registers get random values; the block masks them.
	task automatic set_words(input logic [5:0] r, input logic [7:0] fc, input logic [1:0] fm,
			input logic [7:0] mc, input logic [7:0] pc, input logic [1:0] lc);
		cfg_words[RegRadix] = {2'($urandom), r};
		cfg_words[RegFillChar] = fc;
		cfg_words[RegFillMode] = {6'($urandom), fm};
		cfg_words[RegMinusChar] = mc;
		cfg_words[RegPlusChar] = pc;
		cfg_words[RegLetterCase] = {6'($urandom), lc};
		for (int i = RegLetterCase + 1; i < 8; i++) cfg_words[i] = 8'($urandom);
	endtask

	// The first phases visit the extremes and the overlaps between fill, sign and digits;
	// the rest draw every register at random.
	task automatic choose_config(input int p);
		case (p)
			0: set_words(6'd2, " ", FillLead, "-", "+", CaseEither);
			1: set_words(MaxRadix, "*", FillInner, "~", 8'd0, CaseUpper);
			2: set_words(6'd63, 8'hFF, FillModeSpare, 8'd0, 8'hFF, CaseLower);
			3: set_words(6'd0, "0", FillLead, "x", "y", CaseModeSpare);
			4: set_words(6'd1, 8'd0, FillInner, "-", "-", CaseEither);
			5: set_words(6'd16, "0", FillLead, "a", "+", CaseLower);
			6: set_words(6'd10, "0", FillInner, "0", "1", CaseEither);
			7: set_words(6'd8, "+", FillTrail, "-", "+", CaseUpper);
			default: set_words(6'($urandom_range(0, 63)),
				($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom),
				2'($urandom_range(0, 3)),
				($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
				($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom),
				2'($urandom_range(0, 3)));
		endcase
	endtask

	function automatic logic [7:0] digit_char(input int v);
		logic upper;
		if (v < 10) return ChDigit0 + 8'(v);
		if (case_now == CaseUpper) upper = 1'b1;
		else if (case_now == CaseLower) upper = 1'b0;
		else upper = 1'($urandom);
		return upper ? ChUpperA + 8'(v - 10) : ChLowerA + 8'(v - 10);
	endfunction

	// One string: fill, sign, fill, digits of the current radix and a random stopping
	// character, sometimes followed by characters the block must ignore. A small share
	// is plain noise, and now and then a restart lands in the middle of a string.
	task automatic send_string();
		logic [7:0] text[$];
		logic [5:0] base;
		int         roll;
		int         len;
		base = (radix_now > MaxRadix) ? MaxRadix : radix_now;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			len = $urandom_range(1, 6);
			repeat (len) send_char(8'($urandom), 1'($urandom_range(0, 3) == 0));
			return;
		end
		if (fill_now != 8'd0 && $urandom_range(0, 1) == 1)
			repeat ($urandom_range(1, 3)) text.push_back(fill_now);
		case ($urandom_range(0, 3))
			1: text.push_back(minus_now);
			2: text.push_back(plus_now);
			3: text.push_back(8'($urandom));
			default: ;
		endcase
		if (fill_now != 8'd0 && $urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 2)) text.push_back(fill_now);
		// Mostly short numbers; some long enough to wrap 64 bits, a few long enough
		// to saturate the consumed count.
		roll = $urandom_range(0, 99);
		if (roll < 3) len = $urandom_range(250, 300);
		else if (roll < 18) len = $urandom_range(13, 40);
		else len = $urandom_range(0, 12);
		repeat (len) begin
			if (base == 6'd0) text.push_back(8'($urandom));
			else text.push_back(digit_char($urandom_range(0, base - 1)));
		end
		text.push_back(8'($urandom));
		repeat ($urandom_range(0, 2)) text.push_back(8'($urandom));
		foreach (text[i]) begin
			send_char(text[i], (i == 0) ? ($urandom_range(0, 19) != 0)
				: ($urandom_range(0, 99) == 0));
		end
	endtask

	initial begin
		int phase_target;
		int phase_base;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		radix_now = RadixReset;
		fill_now = 8'd0;
		minus_now = MinusReset;
		plus_now = PlusReset;
		case_now = CaseEither;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed strings under the reset settings.
		// A negative number ended by a comma.
		send_char("-", 1'b1);
		send_char("1", 1'b0);
		send_char("2", 1'b0);
		send_char("3", 1'b0);
		send_char(",", 1'b0);
		// A plus sign with no digits after it, then a digit that comes after the result.
		send_char("+", 1'b1);
		send_char("z", 1'b0);
		send_char("7", 1'b0);
		// A restart drops the unfinished number; the top character code stops the new one.
		send_char("4", 1'b1);
		send_char("2", 1'b0);
		send_char("9", 1'b1);
		send_char(8'hFF, 1'b0);
		// The zero character stops at once.
		send_char(8'h00, 1'b1);
		// A second minus is no digit, so minus zero comes out.
		send_char("-", 1'b1);
		send_char("-", 1'b0);
		// With fill disabled a space is a stopping character.
		send_char(" ", 1'b1);
		// A letter above the radix stops the number.
		send_char("-", 1'b1);
		send_char("0", 1'b0);
		send_char("A", 1'b0);

		// Random phases, each under new settings written while the block is idle. The
		// targets are counted from the start of the random part, so a long string that
		// runs past one target shortens the next phase.
		phase_base = chars_sent;
		for (int p = 0; p < NumPhases; p++) begin
			drain_results();
			choose_config(p);
			write_config();
			if (p == NumPhases - 1) idle_odds = 0;
			else begin
				case (p % 3)
					0: idle_odds = 15;
					1: idle_odds = 0;
					default: idle_odds = 35;
				endcase
			end
			phase_no = p;
			phase_target = phase_base + (p + 1) * RandomItems / NumPhases;
			do send_string(); while (chars_sent < phase_target);
		end

		drain_results();
		if (fail_count == 0 && results_pending == 0) begin
			$display("padded_text_to_integer_parser test passed");
		end else begin
			$display("padded_text_to_integer_parser test failed");
		end
		$finish;
	end

endmodule
